/* rtl/core/fdr_pkg.sv */
// ---------------------------------------------------------------------------
// FDR adjustment package
// Shared widths, defaults and the entry type of the ranking chain.
// ---------------------------------------------------------------------------
package fdr_pkg;
   localparam int DATA_W        = 32;
   localparam int INDEX_W       = 6;
   localparam int MAX_ITEMS_DEF = 64;

   typedef struct packed {
      logic               valid;
      logic [DATA_W-1:0]  value;
      logic [INDEX_W-1:0] index;
   } cell_type;
endpackage

/* rtl/core/fdr_ram.sv */
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module fdr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* rtl/core/fdr_cell.sv */
// ---------------------------------------------------------------------------
// Ranking cell
// One slot of a chain kept in descending order: inserts a new value in
// place, or shifts toward the head during the back pass.
// ---------------------------------------------------------------------------
module fdr_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         insert,
   input  logic                         shift,
   input  logic [fdr_pkg::DATA_W-1:0]   new_value,
   input  logic [fdr_pkg::INDEX_W-1:0]  new_index,
   input  fdr_pkg::cell_type            left_cell,
   input  logic                         left_lt,
   input  fdr_pkg::cell_type            right_cell,
   output fdr_pkg::cell_type            own_cell,
   output logic                         own_lt
);
   fdr_pkg::cell_type cell_ff, cell_in;

   assign own_lt = !cell_ff.valid || (cell_ff.value < new_value);

   always_comb begin
      cell_in = cell_ff;
      if (insert) begin
         if (left_lt) begin
            cell_in = left_cell;
         end else if (own_lt) begin
            cell_in.valid = 1'b1;
            cell_in.value = new_value;
            cell_in.index = new_index;
         end
      end else if (shift) begin
         cell_in = right_cell;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else begin
         cell_ff.valid <= cell_in.valid;
      end
      cell_ff.value <= cell_in.value;
      cell_ff.index <= cell_in.index;
   end

   assign own_cell = cell_ff;
endmodule

/* rtl/core/fdr_divider.sv */
// ---------------------------------------------------------------------------
// Restoring divider
// Unsigned division producing one quotient bit per cycle.
// ---------------------------------------------------------------------------
module fdr_divider #(
   parameter int NUM_W = 39,
   parameter int DEN_W = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);
   localparam int STEP_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0]  work_ff, work_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DEN_W:0]    trial;
   logic [DEN_W:0]    diff;
   logic              ge;

   assign trial = {rem_ff, work_ff[NUM_W-1]};
   assign ge    = trial >= {1'b0, divisor};
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      work_in = work_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         work_in = dividend;
         rem_in  = '0;
         step_in = STEP_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         work_in = {work_ff[NUM_W-2:0], ge};
         rem_in  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = work_ff;
endmodule

/* rtl/core/fdr_pvalue_adjust_top.sv */
// ---------------------------------------------------------------------------
// FDR p-value adjustment
// Step-up false discovery rate adjustment of a batch of Q1.31 p-values.
//
//   channel   direction   contents
//   req       in          p_value in tdata, last_item in tlast
//   rsp       out         adjusted_p and item_index in tdata, last_result in tlast
//
// Requests are taken back to back during loading; a chain of cells keeps the values ranked.
// For each value the back pass multiplies, starts the bit-serial divider, divides and updates.
// Each result is read from the RAM only after the previous one has been taken.
// Reset is synchronous and clears the chain, the counters and the controller.
// A stalled result holds the block; no request is taken until the batch is out.
// ---------------------------------------------------------------------------
module fdr_pvalue_adjust_top #(
   parameter int MAX_ITEMS = fdr_pkg::MAX_ITEMS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] p_value
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] adjusted_p, [37:32] item_index, [39:38] zero
   output logic        rsp_tlast
);
   localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
   localparam int ADDR_W = $clog2(MAX_ITEMS);
   localparam int PROD_W = fdr_pkg::DATA_W + CNT_W;

   typedef enum logic [6:0] {
      S_LOAD  = 7'b0000001,
      S_MULT  = 7'b0000010,
      S_START = 7'b0000100,
      S_DIV   = 7'b0001000,
      S_UPD   = 7'b0010000,
      S_RD    = 7'b0100000,
      S_WT    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          rank_ff, rank_in;
   logic [CNT_W-1:0]          out_ff, out_in;
   logic [fdr_pkg::DATA_W-1:0] min_ff, min_in;
   logic [PROD_W-1:0]         prod_ff, prod_in;
   logic                      send_ff, send_in;
   logic [fdr_pkg::DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic [fdr_pkg::INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic                      rsp_last_ff, rsp_last_in;

   fdr_pkg::cell_type cells [MAX_ITEMS];
   logic              lts   [MAX_ITEMS];
   logic              accept;
   logic              insert;
   logic              shift;
   logic              div_start;
   logic              div_done;
   logic [PROD_W-1:0] quotient;
   logic              ram_we;
   logic [fdr_pkg::DATA_W-1:0] ram_rdata;

   assign req_tready = (state_ff == S_LOAD);
   assign accept     = req_tvalid && req_tready;
   assign insert     = accept && (count_ff < CNT_W'(MAX_ITEMS));
   assign shift      = (state_ff == S_UPD);
   assign div_start  = (state_ff == S_START);
   assign ram_we     = (state_ff == S_UPD);

   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_chain
      fdr_pkg::cell_type left_cell, right_cell;
      logic              left_lt;
      if (i == 0) begin : g_head
         assign left_cell = '0;
         assign left_lt   = 1'b0;
      end else begin : g_body
         assign left_cell = cells[i-1];
         assign left_lt   = lts[i-1];
      end
      if (i == MAX_ITEMS - 1) begin : g_tail
         assign right_cell = '0;
      end else begin : g_inner
         assign right_cell = cells[i+1];
      end
      fdr_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .insert     (insert),
         .shift      (shift),
         .new_value  (req_tdata),
         .new_index  (fdr_pkg::INDEX_W'(count_ff)),
         .left_cell  (left_cell),
         .left_lt    (left_lt),
         .right_cell (right_cell),
         .own_cell   (cells[i]),
         .own_lt     (lts[i])
      );
   end

   fdr_divider #(
      .NUM_W (PROD_W),
      .DEN_W (CNT_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (rank_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   fdr_ram #(
      .WIDTH (fdr_pkg::DATA_W),
      .DEPTH (MAX_ITEMS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (cells[0].index[ADDR_W-1:0]),
      .wr_data (min_in),
      .rd_addr (out_ff[ADDR_W-1:0]),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rank_in      = rank_ff;
      out_in       = out_ff;
      min_in       = min_ff;
      prod_in      = prod_ff;
      send_in      = send_ff;
      rsp_value_in = rsp_value_ff;
      rsp_index_in = rsp_index_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         S_LOAD: begin
            if (accept) begin
               if (insert) begin
                  count_in = count_ff + 1'b1;
               end
               if (req_tlast) begin
                  rank_in  = insert ? count_ff + 1'b1 : count_ff;
                  state_in = S_MULT;
               end
            end
         end
         S_MULT: begin
            prod_in  = PROD_W'(count_ff) * PROD_W'(cells[0].value);
            state_in = S_START;
         end
         S_START: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            if (rank_ff == count_ff) begin
               min_in = cells[0].value;
            end else if (quotient < PROD_W'(min_ff)) begin
               min_in = quotient[fdr_pkg::DATA_W-1:0];
            end
            rank_in = rank_ff - 1'b1;
            if (rank_ff == CNT_W'(1)) begin
               out_in   = '0;
               state_in = S_RD;
            end else begin
               state_in = S_MULT;
            end
         end
         S_RD: begin
            if (!send_ff) begin
               state_in = S_WT;
            end else if (rsp_tready) begin
               send_in = 1'b0;
               if (rsp_last_ff) begin
                  count_in = '0;
                  state_in = S_LOAD;
               end else begin
                  state_in = S_WT;
               end
            end
         end
         S_WT: begin
            send_in      = 1'b1;
            rsp_value_in = ram_rdata;
            rsp_index_in = fdr_pkg::INDEX_W'(out_ff);
            rsp_last_in  = (out_ff == count_ff - 1'b1);
            out_in       = out_ff + 1'b1;
            state_in     = S_RD;
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         count_ff <= '0;
         rank_ff  <= '0;
         out_ff   <= '0;
         min_ff   <= '0;
         send_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rank_ff  <= rank_in;
         out_ff   <= out_in;
         min_ff   <= min_in;
         send_ff  <= send_in;
      end
      prod_ff      <= prod_in;
      rsp_value_ff <= rsp_value_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = send_ff;
   assign rsp_tdata  = {2'b00, rsp_index_ff, rsp_value_ff};
   assign rsp_tlast  = rsp_last_ff;
endmodule

/* tb/sv/fdr_pvalue_adjust_top_tb.sv */
// ---------------------------------------------------------------------------
// FDR p-value adjustment testbench
// Sends batches of Q1.31 p-values to the block and predicts the step-up
// adjusted value of every stored request. A scoreboard compares each result with
// the oldest prediction, field by field, in arrival order.
// ---------------------------------------------------------------------------
module fdr_pvalue_adjust_top_tb;
   localparam int BATCH_MAX = fdr_pkg::MAX_ITEMS_DEF;

   typedef struct packed {
      logic [fdr_pkg::DATA_W-1:0]  adjusted;
      logic [fdr_pkg::INDEX_W-1:0] index;
      logic                        last;
   } adjusted_type;

   class adjust_scoreboard;
      logic [fdr_pkg::DATA_W-1:0] batch_values[$];
      adjusted_type               pending[$];
      int                         errors;

      function void note_request(logic [fdr_pkg::DATA_W-1:0] p_value, logic last_item);
         int                         n;
         int                         order[$];
         int                         j;
         int                         pos;
         logic [63:0]                scaled;
         logic [fdr_pkg::DATA_W-1:0] minimum;
         logic [fdr_pkg::DATA_W-1:0] adjusted[$];
         adjusted_type               entry;
         if (batch_values.size() < BATCH_MAX) batch_values.push_back(p_value);
         if (!last_item) return;
         n = batch_values.size();
         for (int i = 0; i < n; i++) begin
            j = order.size();
            while (j > 0 && batch_values[order[j-1]] > batch_values[i]) j--;
            order.insert(j, i);
            adjusted.push_back('0);
         end
         minimum = '0;
         for (int r = n; r >= 1; r--) begin
            pos = order[r-1];
            scaled = (64'(n) * 64'(batch_values[pos])) / 64'(r);
            if (r == n) minimum = batch_values[pos];
            else if (scaled < 64'(minimum)) minimum = scaled[fdr_pkg::DATA_W-1:0];
            adjusted[pos] = minimum;
         end
         for (int i = 0; i < n; i++) begin
            entry.adjusted = adjusted[i];
            entry.index    = fdr_pkg::INDEX_W'(i);
            entry.last     = (i == n - 1);
            pending.push_back(entry);
         end
         batch_values.delete();
      endfunction

      function void check_result(logic [39:0] tdata, logic tlast);
         adjusted_type exp_r;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result adjusted_p=%h index=%0d last=%b",
                     $time, tdata[31:0], tdata[37:32], tlast);
            errors++;
            return;
         end
         exp_r = pending.pop_front();
         if (tdata[31:0] !== exp_r.adjusted) begin
            $display("%0t: adjusted_p expected %h actual %h", $time, exp_r.adjusted,
                     tdata[31:0]);
            errors++;
         end
         if (tdata[37:32] !== exp_r.index) begin
            $display("%0t: item_index expected %0d actual %0d", $time, exp_r.index,
                     tdata[37:32]);
            errors++;
         end
         if (tlast !== exp_r.last) begin
            $display("%0t: last_result expected %b actual %b", $time, exp_r.last, tlast);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tlast = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;

   adjust_scoreboard board = new();
   bit   send_steady = 0;
   bit   recv_steady = 0;
   bit   hold_off    = 0;
   bit   done        = 0;
   int   quiet_cycles = 0;

   localparam int QUIET_LIMIT = 200000;

   fdr_pvalue_adjust_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) board.note_request(req_tdata, req_tlast);
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata, rsp_tlast);
   end

   always @(posedge clock) begin
      if (hold_off) rsp_tready <= 0;
      else rsp_tready <= recv_steady || ($urandom_range(99) >= 8);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic send_request(logic [31:0] p_value, logic last_item);
      while (!send_steady && $urandom_range(99) < 8) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= p_value;
      req_tlast  <= last_item;
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic logic [31:0] random_p();
      case ($urandom_range(9))
         0:       return 32'h8000_0000;
         1:       return 32'(0);
         2:       return $urandom();
         3:       return 32'h8000_0000 - $urandom_range(3);
         4:       return $urandom_range(15);
         default: return $urandom_range(32'h8000_0000);
      endcase
   endfunction

   task automatic send_batch(int count);
      logic [31:0] tie;
      tie = random_p();
      for (int i = 0; i < count; i++)
         send_request(($urandom_range(3) == 0) ? tie : random_p(), i == count - 1);
   endtask

   initial begin
      int sent;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_request(32'h8000_0000, 1);
      send_request(32'h0000_0000, 0);
      send_request(32'hFFFF_FFFF, 1);
      send_request(32'h0000_0001, 0);
      send_request(32'h0000_0001, 0);
      send_request(32'h0000_0001, 1);
      send_request(32'h4000_0000, 0);
      send_request(32'h2000_0000, 0);
      send_request(32'h8000_0000, 0);
      send_request(32'h0000_0000, 1);
      send_request(32'h5555_5555, 0);
      send_request(32'hAAAA_AAAA, 1);
      sent = 12;

      // Overflow batch: beyond the store capacity, the last three requests are dropped.
      for (int i = 0; i < BATCH_MAX + 3; i++)
         send_request(random_p(), i == BATCH_MAX + 2);
      sent += BATCH_MAX + 3;

      fork
         begin
            hold_off = 1;
            repeat (3000) @(posedge clock);
            hold_off = 0;
         end
         begin
            send_batch(20);
            send_batch(20);
            req_tvalid <= 0;
         end
      join
      sent += 40;

      send_steady = 1;
      recv_steady = 1;
      send_batch(BATCH_MAX);
      sent += BATCH_MAX;
      send_steady = 0;
      recv_steady = 0;

      while (sent < 430) begin
         int count;
         count = ($urandom_range(9) == 0) ? $urandom_range(BATCH_MAX, 40)
                                          : $urandom_range(8, 1);
         if (count > 430 - sent) count = 430 - sent;
         send_batch(count);
         sent += count;
      end
      req_tvalid <= 0;
      @(posedge clock);

      while (board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      done = 1;
   end

   initial begin
      wait (done);
      if (board.errors == 0 && board.pending.size() == 0 && board.batch_values.size() == 0)
         $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end
endmodule
